>>> hdl/kvbt_pkg.sv
// kvbt_pkg: sizes, operation and status codes, and the transfer structs of the
// key/value binding table
// no dependencies
package kvbt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned KEY_BITS    = 16;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_GET     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_REPLACE = 2'd3
  } kvbt_func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } kvbt_status_e;

  typedef struct packed {
    kvbt_func_e            func;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } kvbt_req_t;

  typedef struct packed {
    kvbt_status_e          status;
    logic [VALUE_BITS-1:0] found_value;
    logic [COUNT_W-1:0]    bindings;
  } kvbt_res_t;

endpackage

>>> hdl/key_value_binding_table.sv
// key_value_binding_table: sixteen-slot associative table, put/get/remove/replace
// one operation per transfer, one result per operation
// depends on kvbt_pkg
//
//   channel   direction  handshake              payload
//   request   in         start_i, busy_o        req_i   (kvbt_req_t)
//   result    out        res_valid_o strobe     res_o   (kvbt_res_t)
//
// a request is taken at every edge with start_i high; busy_o stays low
// path: request register, then all slots compared in parallel
// and the table and result register updated at the same edge
// one operation per cycle sustained, set by the single compare-and-update pass
// reset clears the valid marks and the count; keys and values need no reset
// the receiver cannot stall: each result is shown for exactly one cycle
module key_value_binding_table
  import kvbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  kvbt_req_t req_i,
  output logic      res_valid_o,
  output kvbt_res_t res_o
);

  logic                  req_valid_q;
  kvbt_req_t             req_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q   [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] value_q [TABLE_DEPTH];
  logic [COUNT_W-1:0]    count_q, count_d;
  logic                  res_valid_q;
  kvbt_res_t             res_q, res_d;

  logic [TABLE_DEPTH-1:0] hit;
  logic [TABLE_DEPTH-1:0] free_sel;
  logic [TABLE_DEPTH-1:0] write_sel;
  logic [VALUE_BITS-1:0]  hit_value;
  logic                   any_hit;
  logic                   any_free;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
  end

  // parallel match and lowest free slot
  always_comb begin
    logic taken;
    hit_value = '0;
    taken     = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i]      = valid_q[i] && (key_q[i] == req_q.key);
      hit_value   = hit_value | (value_q[i] & {VALUE_BITS{hit[i]}});
      free_sel[i] = !valid_q[i] && !taken;
      taken       = taken | !valid_q[i];
    end
  end

  assign any_hit  = |hit;
  assign any_free = |free_sel;

  always_comb begin
    valid_d   = valid_q;
    count_d   = count_q;
    write_sel = '0;
    res_d.status      = ST_OK;
    res_d.found_value = '0;
    if (req_valid_q) begin
      unique case (req_q.func)
        OP_PUT: begin
          if (any_hit) begin
            res_d.status = ST_PRESENT;
          end else if (!any_free) begin
            res_d.status = ST_FULL;
          end else begin
            write_sel = free_sel;
            valid_d   = valid_q | free_sel;
            count_d   = count_q + COUNT_W'(1);
          end
        end
        OP_GET: begin
          if (!any_hit) begin
            res_d.status = ST_ABSENT;
          end else begin
            res_d.found_value = hit_value;
          end
        end
        OP_REMOVE: begin
          if (!any_hit) begin
            res_d.status = ST_ABSENT;
          end else begin
            res_d.found_value = hit_value;
            valid_d           = valid_q & ~hit;
            count_d           = count_q - COUNT_W'(1);
          end
        end
        OP_REPLACE: begin
          if (!any_hit) begin
            res_d.status = ST_ABSENT;
          end else begin
            write_sel = hit;
          end
        end
        default: begin
          res_d.status = ST_OK;
        end
      endcase
    end
    res_d.bindings = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      count_q     <= count_d;
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (write_sel[i]) begin
        value_q[i] <= req_q.value;
        if (req_q.func == OP_PUT) begin
          key_q[i] <= req_q.key;
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // keys are unique among valid slots
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one slot matches the key");

  a_count_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("binding count differs from valid slots");

  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> res_valid_q)
    else $error("request produced no result");

  a_full_put_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && req_q.func == OP_PUT && !any_hit && (&valid_q))
    |=> (res_q.status == ST_FULL && $stable(valid_q)))
    else $error("put into a full table changed it");

endmodule
